>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL of the search unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define SAS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> hdl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and constants of the sorted array search unit.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int SAS_DEPTH = 1024;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 10;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_EXACT   = 2'd1,
        KIND_LOWEST  = 2'd2,
        KIND_HIGHEST = 2'd3
    } t_kind;

    // Response status codes
    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

endpackage

>>> hdl/sas_if.sv
// ----------------------------------------------------------------------------
// sas_req_if / sas_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface sas_req_if;
    import sas_pkg::*;

    logic                        valid;
    logic                        ready;
    t_kind                       kind;
    logic signed [VALUE_W-1:0]   value;
    logic                        start_new;

    modport source (output valid, output kind, output value, output start_new, input ready);
    modport sink   (input valid, input kind, input value, input start_new, output ready);
endinterface

interface sas_rsp_if;
    import sas_pkg::*;

    logic                 valid;
    logic                 ready;
    t_status              status;
    logic [INDEX_W-1:0]   index;

    modport source (output valid, output status, output index, input ready);
    modport sink   (input valid, input status, input index, output ready);
endinterface

>>> hdl/sas_ram.sv
// ----------------------------------------------------------------------------
// sas_ram
// Simple dual-port element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sas_ram #(
    parameter int DEPTH = sas_pkg::SAS_DEPTH,
    parameter int AW    = 10,
    parameter int DW    = sas_pkg::VALUE_W
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [DW-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [DW-1:0] o_rdata
);
    logic signed [DW-1:0] mem [0:DEPTH-1];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

>>> hdl/sorted_array_search_unit.sv
// Load: accept, write and output register, in that order, before the result word.
// Search: a RAM read and a compare per probe, up to log2(DEPTH)+1 probes, plus accept,
//   start, closing window test, one check read for lowest and highest modes and the output
//   register. The single RAM read port sets the probe rate.
// One request in flight; a new one is taken while the last result word waits.
// Reset clears the element count and the handshakes; the store keeps its data.
// ----------------------------------------------------------------------------
// sorted_array_search_unit
// Ascending array store with exact, lower-bound and upper-bound binary search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_array_search_unit #(
    parameter int DEPTH = sas_pkg::SAS_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sas_req_if.sink    i_req,
    sas_rsp_if.source  o_rsp
);
    import sas_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_PROBE = 6'b000100,
        S_CMP   = 6'b001000,
        S_CHECK = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    t_kind                       r_kind;
    logic signed [VALUE_W-1:0]   r_val;
    logic                        r_new;
    logic [CW-1:0]               r_lo, n_lo;
    logic [CW-1:0]               r_he, n_he;
    logic [CW-1:0]               r_mid, n_mid;
    t_status                     r_status, n_status;
    logic [INDEX_W-1:0]          r_index, n_index;
    logic                        r_ov, n_ov;
    t_status                     r_ostatus;
    logic [INDEX_W-1:0]          r_oindex;

    logic                        req_fire;
    logic                        out_free;
    logic                        out_load;
    logic [CW-1:0]               span;
    logic [CW-1:0]               half;
    logic [CW-1:0]               probe_mid;
    logic [CW-1:0]               tail_hi;
    logic [CW-1:0]               ld_pos;
    logic                        ld_full;
    logic [CW+INDEX_W-1:0]       mid_wide;
    logic [INDEX_W-1:0]          mid_index;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic signed [VALUE_W-1:0]   ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic signed [VALUE_W-1:0]   ram_rdata;
    logic                        el_eq;
    logic                        el_lt;

    // Element store
    sas_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshakes
    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_ov || o_rsp.ready;
    assign out_load    = (r_state == S_OUT) && out_free;

    // Floor midpoint of the half-open window: lower middle for exact mode, upper middle for bounds
    assign span      = r_he - r_lo;
    assign half      = (r_kind == KIND_EXACT) ? ((span - CW'(1)) >> 1) : (span >> 1);
    assign probe_mid = r_lo + half;
    assign tail_hi   = r_lo - CW'(1);

    // Append position
    assign ld_pos  = r_new ? '0 : r_count;
    assign ld_full = (ld_pos >= CW'(DEPTH));

    // Report index in its low bits
    assign mid_wide  = {{INDEX_W{1'b0}}, r_mid};
    assign mid_index = mid_wide[INDEX_W-1:0];

    // Element compare
    assign el_eq = (ram_rdata == r_val);
    assign el_lt = (ram_rdata < r_val);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_he      = r_he;
        n_mid     = r_mid;
        n_status  = r_status;
        n_index   = r_index;
        ram_we    = 1'b0;
        ram_waddr = ld_pos[AW-1:0];
        ram_wdata = r_val;
        ram_raddr = probe_mid[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_kind == KIND_LOAD) begin
                    n_index = '0;
                    n_state = S_OUT;
                    if (ld_full) begin
                        n_status = ST_DROPPED;
                    end else begin
                        ram_we   = 1'b1;
                        n_count  = ld_pos + CW'(1);
                        n_status = ST_LOADED;
                    end
                end else begin
                    n_lo    = '0;
                    n_he    = r_count;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_he) begin
                    n_mid   = probe_mid;
                    n_state = S_CMP;
                end else begin
                    n_status = ST_MISSING;
                    n_index  = '0;
                    n_state  = S_OUT;
                    if (r_kind == KIND_LOWEST && r_lo < r_count) begin
                        n_mid     = r_lo;
                        ram_raddr = r_lo[AW-1:0];
                        n_state   = S_CHECK;
                    end else if (r_kind == KIND_HIGHEST && r_lo != '0) begin
                        n_mid     = tail_hi;
                        ram_raddr = tail_hi[AW-1:0];
                        n_state   = S_CHECK;
                    end
                end
            end
            S_CMP: begin
                n_state = S_PROBE;
                if (r_kind == KIND_EXACT) begin
                    if (el_eq) begin
                        n_status = ST_FOUND;
                        n_index  = mid_index;
                        n_state  = S_OUT;
                    end else if (el_lt) begin
                        n_lo = r_mid + CW'(1);
                    end else begin
                        n_he = r_mid;
                    end
                end else if (el_lt || (r_kind == KIND_HIGHEST && el_eq)) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_he = r_mid;
                end
            end
            S_CHECK: begin
                n_state = S_OUT;
                if (el_eq) begin
                    n_status = ST_FOUND;
                    n_index  = mid_index;
                end else begin
                    n_status = ST_MISSING;
                    n_index  = '0;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_comb begin
        n_ov = r_ov;
        if (out_load) begin
            n_ov = 1'b1;
        end else if (o_rsp.ready) begin
            n_ov = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_kind <= i_req.kind;
            r_val  <= i_req.value;
            r_new  <= i_req.start_new;
        end
        r_lo     <= n_lo;
        r_he     <= n_he;
        r_mid    <= n_mid;
        r_status <= n_status;
        r_index  <= n_index;
        if (out_load) begin
            r_ostatus <= r_status;
            r_oindex  <= r_index;
        end
    end

    assign o_rsp.valid  = r_ov;
    assign o_rsp.status = r_ostatus;
    assign o_rsp.index  = r_oindex;

    // Checks
    `SAS_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "element count above depth")
    `SAS_ASSERT(a_accept_start, req_fire |=> (r_state == S_START), "accepted word not started")
    `SAS_ASSERT(a_probe_window, (r_state == S_CMP) |-> (r_mid >= r_lo && r_mid < r_he), "probe outside window")
    `SAS_ASSERT(a_window_order, (r_state == S_PROBE) |-> (r_lo <= r_he && r_he <= r_count), "search window inverted")
    `SAS_ASSERT(a_result_sent, out_load |=> r_ov, "result word not presented")

endmodule
